### design/fic_pkg.sv
package fic_pkg;

   localparam int VALUE_W = 16;
   localparam int COEF_W  = 37;
   localparam int INDEX_W = 6;
   localparam int LEN_W   = 6;
   localparam int N_W     = 7;
   localparam int PROD_W  = 2 * VALUE_W;

   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   typedef struct packed {
      logic [1:0]                 command;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0]   coefficient;
      logic [INDEX_W-1:0]         index;
      logic                       last;
      logic                       error;
   } rsp_type;

   typedef struct packed {
      logic issue;
      logic clear;
   } mac_ctl_type;

endpackage

### design/fic_ram.sv
module fic_ram #(
   parameter int WIDTH      = 16,
   parameter int DEPTH      = 32,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

### design/fic_mac.sv
module fic_mac import fic_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mac_ctl_type               ctl,
   input  logic signed [VALUE_W-1:0] a_data,
   input  logic signed [VALUE_W-1:0] b_data,
   output logic signed [COEF_W-1:0]  acc_ff,
   output logic                      busy
);

   logic                     v1_ff;
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // ram data shows up in the cycle after issue
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_ff <= a_data * b_data;
      end
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + COEF_W'(prod_ff);
      end
   end

   assign busy = v1_ff | v2_ff;

endmodule

### design/fft_integer_convolution.sv
// integer convolution engine
// req channel: present req with start high; the word is taken on a clock edge
// where busy is low. command 0 appends value to sequence a, 1 appends to b,
// 2 computes, 3 is ignored. loads beyond MAX_LEN samples are dropped and
// flag an error for the next compute.
// rsp channel: one word per coefficient, rsp_valid high for exactly one
// cycle; the receiver cannot stall, so every word must be taken on sight.
// n words are sent, n the smallest power of two at or above la+lb-1, last
// marks the final one. an empty sequence yields one error word.
// load: busy stays low.
// compute: each coefficient k passes a setup step, then walks its product
// terms through one read port of each sample store and one 16x16 multiplier,
// one term per cycle, then waits for the mac pipeline to drain and outputs;
// padding coefficients take only setup and output. the single mac carries
// every product term.
// the first word follows setup, term walk, drain and output of coefficient
// 0; when a sequence is empty the compute goes straight to output.
// reset clears lengths, error flag and control; sample stores need no clear.
module fft_integer_convolution import fic_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic             ovf_ff, ovf_in;
   logic [LEN_W-1:0] la_ff, la_in, lb_ff, lb_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic             err_ff, err_in;
   logic             empty_ff, empty_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             wr_a, wr_b;
   logic [LEN_W-1:0] total_c, i_lo, i_hi, b_idx;
   logic [N_W-1:0]   n_c;
   logic             last_c;
   mac_ctl_type      mac_ctl;
   logic [VALUE_W-1:0] a_rd, b_rd;
   logic signed [COEF_W-1:0] acc;
   logic             mac_busy;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_a   = accept && (req.command == CMD_LOAD_A) && (len_a_ff < LEN_W'(MAX_LEN));
   assign wr_b   = accept && (req.command == CMD_LOAD_B) && (len_b_ff < LEN_W'(MAX_LEN));

   // padded length: smallest power of two covering la+lb-1
   always_comb begin
      total_c = len_a_ff + len_b_ff - LEN_W'(1);
      n_c     = N_W'(64);
      for (int p = N_W - 1; p >= 0; p--) begin
         if ((N_W'(1) << p) >= {1'b0, total_c}) begin
            n_c = N_W'(1) << p;
         end
      end
   end

   // term range for coefficient k
   always_comb begin
      i_lo   = (k_ff >= lb_ff) ? (k_ff - lb_ff + LEN_W'(1)) : '0;
      i_hi   = (k_ff < la_ff) ? k_ff : (la_ff - LEN_W'(1));
      b_idx  = k_ff - i_ff;
      last_c = empty_ff || ({1'b0, k_ff} + N_W'(1) == n_ff);
   end

   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      total_in     = total_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      empty_in     = empty_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mac_ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req.command == CMD_LOAD_A) begin
                  if (wr_a) len_a_in = len_a_ff + LEN_W'(1);
                  else      ovf_in   = 1'b1;
               end else if (req.command == CMD_LOAD_B) begin
                  if (wr_b) len_b_in = len_b_ff + LEN_W'(1);
                  else      ovf_in   = 1'b1;
               end else if (req.command == CMD_COMPUTE) begin
                  la_in    = len_a_ff;
                  lb_in    = len_b_ff;
                  total_in = total_c;
                  n_in     = n_c;
                  err_in   = ovf_ff;
                  empty_in = (len_a_ff == '0) || (len_b_ff == '0);
                  k_in     = '0;
                  len_a_in = '0;
                  len_b_in = '0;
                  ovf_in   = 1'b0;
                  mac_ctl.clear = 1'b1;
                  state_in = empty_in ? ST_EMIT : ST_SETUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SETUP: begin
            mac_ctl.clear = 1'b1;
            i_in = i_lo;
            // padding coefficients have no terms
            state_in = (k_ff < total_ff) ? ST_ISSUE : ST_EMIT;
         end
         ST_ISSUE: begin
            mac_ctl.issue = 1'b1;
            if (i_ff == i_hi) state_in = ST_DRAIN;
            else              i_in     = i_ff + LEN_W'(1);
         end
         ST_DRAIN: begin
            if (!mac_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.coefficient = empty_ff ? '0 : acc;
            rsp_in.index       = INDEX_W'(k_ff);
            rsp_in.last        = last_c;
            rsp_in.error       = err_ff || empty_ff;
            if (last_c) begin
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + LEN_W'(1);
               state_in = ST_SETUP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      la_ff    <= la_in;
      lb_ff    <= lb_in;
      total_ff <= total_in;
      n_ff     <= n_in;
      err_ff   <= err_in;
      empty_ff <= empty_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      rsp_ff   <= rsp_in;
   end

   // sample stores, one write port for loads, one read port for the mac
   fic_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_store_a (
      .clock      (clock),
      .wr_en      (wr_a),
      .wr_addr    (len_a_ff[AW-1:0]),
      .wr_data    (req.value),
      .rd_addr    (i_ff[AW-1:0]),
      .rd_data_ff (a_rd)
   );

   fic_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_store_b (
      .clock      (clock),
      .wr_en      (wr_b),
      .wr_addr    (len_b_ff[AW-1:0]),
      .wr_data    (req.value),
      .rd_addr    (b_idx[AW-1:0]),
      .rd_data_ff (b_rd)
   );

   fic_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a_data (a_rd),
      .b_data (b_rd),
      .acc_ff (acc),
      .busy   (mac_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   // every word comes out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("word sent without emit step");

   // mac pipeline is empty whenever a coefficient is sent
   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !mac_busy)
      else $error("coefficient sent before mac drained");

   // term walk never passes its upper bound
   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (i_ff <= i_hi))
      else $error("term index out of range");
`endif

endmodule
